// ----- sv/prince_pkg.sv -----
// ----------------------------------------------------------------------------
// prince_pkg
// Shared types, tables and round functions of the PRINCE-style block cipher.
// ----------------------------------------------------------------------------
package prince_pkg;

  localparam int BlockW = 64;
  localparam int NumStages = 11;
  localparam int AddrW = 4;

  typedef enum logic [1:0] {
    MODE_FWD,
    MODE_MID,
    MODE_BWD
  } round_mode_e;

  typedef struct packed {
    logic              valid;
    logic [BlockW-1:0] data;
  } stage_t;

  localparam logic [BlockW-1:0] ROUND_CONST [12] = '{
    64'h0000000000000000, 64'h13198A2E03707344, 64'hA4093822299F31D0,
    64'h082EFA98EC4E6C89, 64'h452821E638D01377, 64'hBE5466CF34E90C6C,
    64'h7EF84F78FD955CB1, 64'h85840851F1AC43AA, 64'hC882D32F25323C54,
    64'h64A51195E0E3610D, 64'hD3B5A399CA0C2399, 64'hC0AC29B7C97C50DD
  };

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'h4, 4'h7, 4'h2, 4'h1, 4'h8, 4'hB, 4'hE, 4'hD,
    4'hF, 4'hC, 4'h9, 4'hA, 4'h3, 4'h0, 4'h5, 4'h6
  };

  localparam logic [3:0] SBOX_INV [16] = '{
    4'hD, 4'h3, 4'h2, 4'hC, 4'h0, 4'hE, 4'hF, 4'h1,
    4'h4, 4'hA, 4'hB, 4'h5, 4'h9, 4'h7, 4'h6, 4'h8
  };

  localparam logic [3:0] PERM_FWD [16] = '{
    4'd14, 4'd3, 4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1,
    4'd6, 4'd11, 4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9
  };

  localparam logic [3:0] PERM_BWD [16] = '{
    4'd6, 4'd3, 4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1,
    4'd14, 4'd11, 4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9
  };

  localparam logic [1:0] MixA = 2'd3;
  localparam logic [1:0] MixB = 2'd0;

  function automatic logic [BlockW-1:0] sub_fwd(logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = SBOX_FWD[s[4*i +: 4]];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] sub_inv(logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = SBOX_INV[s[4*i +: 4]];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] perm_fwd(logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = s[4*PERM_FWD[n] +: 4];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] perm_bwd(logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = s[4*PERM_BWD[n] +: 4];
    end
    return r;
  endfunction

  function automatic logic [15:0] mix16(logic [15:0] x, logic [1:0] d);
    logic [15:0] r;
    logic [1:0]  skip;
    logic        bit_v;
    r = '0;
    for (int g = 0; g < 4; g++) begin
      for (int b = 0; b < 4; b++) begin
        skip  = 2'(b) + d - 2'(g);
        bit_v = 1'b0;
        for (int j = 0; j < 4; j++) begin
          if (2'(j) != skip) begin
            bit_v = bit_v ^ x[4*j+b];
          end
        end
        r[4*g+b] = bit_v;
      end
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] mprime(logic [BlockW-1:0] s);
    return {mix16(s[63:48], MixA), mix16(s[47:32], MixB),
            mix16(s[31:16], MixB), mix16(s[15:0], MixA)};
  endfunction

endpackage

// ----- sv/prince_round.sv -----
// ----------------------------------------------------------------------------
// prince_round
// One registered round of the cipher: forward, middle or backward form.
// ----------------------------------------------------------------------------
module prince_round import prince_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  round_mode_e       mode_i,
  input  logic [BlockW-1:0] rc_i,
  input  logic [BlockW-1:0] key_i,
  input  stage_t            in_i,
  output stage_t            out_o
);

  logic [BlockW-1:0] data_d;
  logic [BlockW-1:0] data_q;
  logic              valid_q;

  always_comb begin
    case (mode_i)
      MODE_FWD: data_d = perm_fwd(mprime(sub_fwd(in_i.data))) ^ key_i ^ rc_i;
      MODE_MID: data_d = sub_inv(mprime(sub_fwd(in_i.data)));
      MODE_BWD: data_d = sub_inv(mprime(perm_bwd(in_i.data ^ key_i ^ rc_i)));
      default:  data_d = in_i.data;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_o = '{valid: valid_q, data: data_q};

endmodule

// ----- sv/prince_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// prince_block_encrypt
// Pipelined PRINCE-style 64-bit block encryption under two 64-bit keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive plain_block_i and raise start; the item is taken at each
//   rising edge with start high and busy low. busy stays low, so one item
//   enters every cycle.
//   Output: done_o is high for one cycle with cipher_block_o; the result of
//   an item taken at an edge passes 13 register stages before it shows
//   (input whitening, five forward rounds, the middle round, five backward
//   rounds, output whitening).
//   Throughput: one item per cycle, set by one round per pipeline stage.
//   Config: APB port with 64-bit data. Address 0 holds the whitening key,
//   address 8 the core key; write only while the pipeline is empty.
//   Reset: clears both keys and all stage valid bits; in-flight items drop.
//   The receiver cannot stall: every result is offered exactly once.
// ----------------------------------------------------------------------------
module prince_block_encrypt import prince_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [BlockW-1:0] plain_block_i,
  output logic              done_o,
  output logic [BlockW-1:0] cipher_block_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [BlockW-1:0] pwdata,
  output logic [BlockW-1:0] prdata,
  output logic              pready
);

  logic [BlockW-1:0] k0_q;
  logic [BlockW-1:0] k1_q;
  logic [BlockW-1:0] k0p;
  logic              wr_en;

  logic              in_valid_q;
  logic [BlockW-1:0] in_data_q;
  logic              out_valid_q;
  logic [BlockW-1:0] out_data_q;
  stage_t            stage [NumStages+1];

  round_mode_e       mode_tab [NumStages];

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = paddr[3] ? k1_q : k0_q;
  assign k0p    = {k0_q[0], k0_q[BlockW-1:1]} ^ {{(BlockW-1){1'b0}}, k0_q[BlockW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k0_q <= '0;
      k1_q <= '0;
    end else if (wr_en) begin
      if (paddr[3]) begin
        k1_q <= pwdata;
      end else begin
        k0_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start && !busy;
      out_valid_q <= stage[NumStages].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    in_data_q  <= plain_block_i ^ k0_q ^ k1_q;
    out_data_q <= stage[NumStages].data ^ k1_q ^ k0p ^ ROUND_CONST[11];
  end

  assign stage[0] = '{valid: in_valid_q, data: in_data_q};

  for (genvar r = 0; r < NumStages; r++) begin : g_round
    assign mode_tab[r] = (r < 5) ? MODE_FWD : ((r == 5) ? MODE_MID : MODE_BWD);

    prince_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .mode_i (mode_tab[r]),
      .rc_i   ((r < 5) ? ROUND_CONST[r+1] : ROUND_CONST[r]),
      .key_i  (k1_q),
      .in_i   (stage[r]),
      .out_o  (stage[r+1])
    );
  end

  assign done_o         = out_valid_q;
  assign cipher_block_o = out_data_q;

endmodule

// ----- sv/prince_chk.sv -----
// ----------------------------------------------------------------------------
// prince_chk
// Port-level checks of the encryption pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module prince_chk import prince_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [AddrW-1:0]  paddr,
  input logic [BlockW-1:0] pwdata,
  input logic [BlockW-1:0] prdata,
  input logic              pready
);

  localparam int Latency = NumStages + 2;

  logic accept;
  assign accept = start && !busy;

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_item_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
      accept |-> ##Latency done_o)
    else $error("item lost in pipeline");

  a_done_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> $past(accept, Latency))
    else $error("result without item");

  a_write_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (psel && penable && pwrite && pready) ##1 (paddr == $past(paddr))
      |-> prdata == $past(pwdata))
    else $error("key readback mismatch");

endmodule

bind prince_block_encrypt prince_chk u_chk (.*);
